// ===== sv/erv_pkg.sv =====
package erv_pkg;

  // Fan size and field formats
  localparam int MAX_VECTORS = 64;
  localparam int CNT_W       = 7;

  // Angle units: 1/128 degree
  localparam int TURN    = 46080;
  localparam int QUARTER = 11520;
  localparam int EIGHTH  = 5760;

  // Output saturation, Q12.4
  localparam int OUT_LIMIT = 65520;

  // One in Q2.30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Radian conversion: xr = (a * 3373259426 + 11520) / 23040, split as
  // a * XR_MUL_HI + (a * XR_MUL_LO + 11520) / 23040
  localparam int XR_MUL_HI = 146408;
  localparam int XR_MUL_LO = 19106;
  localparam int XR_BIAS   = 11520;
  localparam int XR_DIV    = 23040;
  localparam int XR_RECIP  = 186413;  // floor(2^32 / 23040)

  // Series step indexes: sine steps first, then cosine steps
  localparam logic [3:0] SIN_FIRST = 4'd0;
  localparam logic [3:0] SIN_LAST  = 4'd4;
  localparam logic [3:0] COS_FIRST = 4'd5;
  localparam logic [3:0] COS_LAST  = 4'd10;

  typedef struct packed {
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic [6:0]         vector_count;
    logic signed [16:0] spread_angle;
    logic [11:0]        length;
  } in_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE,
    OP_DIV_A,
    OP_DIV_A_SAVE,
    OP_DIV_N,
    OP_DIV_N_SAVE,
    OP_ZERO,
    OP_FOLD,
    OP_XR_PB,
    OP_XR_EST,
    OP_XR_FIX,
    OP_XR_SUM,
    OP_X2_MUL,
    OP_RND_X2,
    OP_T_INIT,
    OP_H_MUL,
    OP_RND_P,
    OP_H_EST,
    OP_H_UPD,
    OP_S_MUL,
    OP_RND_S,
    OP_C_SAVE,
    OP_QUAD,
    OP_RM1,
    OP_RM2,
    OP_RM3,
    OP_RM4,
    OP_OUT,
    OP_NEXT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] kidx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic n_zero;
    logic n_one;
    logic last_vec;
    logic out_busy;
  } stat_t;

  // Series divisors
  function automatic logic [7:0] k_of(input logic [3:0] idx);
    logic [7:0] k;
    case (idx)
      4'd0:    k = 8'd110;
      4'd1:    k = 8'd72;
      4'd2:    k = 8'd42;
      4'd3:    k = 8'd20;
      4'd4:    k = 8'd6;
      4'd5:    k = 8'd132;
      4'd6:    k = 8'd90;
      4'd7:    k = 8'd56;
      4'd8:    k = 8'd30;
      4'd9:    k = 8'd12;
      4'd10:   k = 8'd2;
      default: k = 8'd1;
    endcase
    return k;
  endfunction

  // floor(2^32 / k) for the series divisors
  function automatic logic [31:0] m_of(input logic [3:0] idx);
    logic [31:0] m;
    case (idx)
      4'd0:    m = 32'd39045157;
      4'd1:    m = 32'd59652323;
      4'd2:    m = 32'd102261126;
      4'd3:    m = 32'd214748364;
      4'd4:    m = 32'd715827882;
      4'd5:    m = 32'd32537631;
      4'd6:    m = 32'd47721858;
      4'd7:    m = 32'd76695844;
      4'd8:    m = 32'd143165576;
      4'd9:    m = 32'd357913941;
      4'd10:   m = 32'd2147483648;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Saturate to the output range
  function automatic logic signed [16:0] clamp_out(input logic signed [20:0] v);
    logic signed [16:0] r;
    if (v > 21'(OUT_LIMIT)) begin
      r = 17'(OUT_LIMIT);
    end else if (v < -21'(OUT_LIMIT)) begin
      r = -17'(OUT_LIMIT);
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/erv_if.sv =====
interface erv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] fwd_x;
  logic signed [15:0] fwd_y;
  logic signed [15:0] fwd_z;
  logic [6:0]         vector_count;
  logic signed [16:0] spread_angle;
  logic [11:0]        length;

  modport source (output valid, fwd_x, fwd_y, fwd_z, vector_count, spread_angle, length,
                  input ready);
  modport sink (input valid, fwd_x, fwd_y, fwd_z, vector_count, spread_angle, length,
                output ready);
endinterface

interface erv_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] out_x;
  logic signed [16:0] out_y;
  logic signed [16:0] out_z;
  logic               last;

  modport source (output valid, out_x, out_y, out_z, last, input ready);
  modport sink (input valid, out_x, out_y, out_z, last, output ready);
endinterface

// ===== sv/erv_div.sv =====
// Restoring divider, one quotient bit per cycle, floor semantics for a
// signed dividend over a positive divisor
module erv_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [23:0] dividend,
  input  logic [7:0]         divisor,
  output logic               done,
  output logic signed [17:0] quo,
  output logic [7:0]         rem
);

  logic              busy_r;
  logic              fix_r;
  logic              done_r;
  logic [4:0]        cnt_r;
  logic [23:0]       qsh_r;
  logic [7:0]        acc_r;
  logic [7:0]        dvs_r;
  logic              neg_r;
  logic signed [17:0] quo_r;
  logic [7:0]        rem_r;

  logic [8:0]        trial;
  logic [8:0]        diff;
  logic              take;
  logic signed [24:0] uq;

  // one trial subtraction
  always_comb begin
    trial = {acc_r, qsh_r[23]};
    diff  = trial - {1'b0, dvs_r};
    take  = (trial >= {1'b0, dvs_r});
    uq    = $signed({1'b0, qsh_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fix_r;
      fix_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd23;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[23];
      qsh_r <= dividend[23] ? 24'(-dividend) : dividend;
      acc_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      acc_r <= take ? diff[7:0] : trial[7:0];
      qsh_r <= {qsh_r[22:0], take};
    end
    // floor correction for negative dividends
    if (fix_r) begin
      if (!neg_r) begin
        quo_r <= uq[17:0];
        rem_r <= acc_r;
      end else if (acc_r == 8'd0) begin
        quo_r <= 18'(-uq);
        rem_r <= 8'd0;
      end else begin
        quo_r <= 18'(-uq - 25'sd1);
        rem_r <= dvs_r - acc_r;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== sv/erv_dp.sv =====
// Datapath: operand registers, one shared unsigned multiplier for the
// radian conversion and series, one shared signed multiplier for the
// rotation, angle stepping and the output register
module erv_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  erv_pkg::cmd_t     cmd,
  input  erv_pkg::in_item_t item,
  output erv_pkg::stat_t    stat,
  erv_out_if.source         out_ch
);

  // item registers
  logic signed [15:0] fx_r, fy_r;
  logic [11:0]        len_r;
  logic signed [16:0] ang_r;
  logic [6:0]         n_r;
  logic signed [27:0] vx_r, vy_r;
  logic signed [16:0] oz_r;
  logic signed [23:0] n0_r;
  logic [7:0]         d_r;

  // angle stepping
  logic signed [17:0] q_r, qs_r;
  logic [7:0]         r_r, rs_r;
  logic [5:0]         idx_r;

  // per-vector trig registers
  logic [1:0]         quad_r;
  logic               swap_r;
  logic [12:0]        af_r;
  logic [26:0]        pb_r;
  logic [12:0]        est_r;
  logic [29:0]        xr_r, x2_r, p_r;
  logic [30:0]        t_r, s0_r, c0_r;
  logic signed [31:0] s_r, c_r;
  logic [63:0]        prod_r;
  logic signed [59:0] m1_r, m2_r, m3_r, m4_r;

  // output register
  logic               ov_r;
  logic signed [16:0] ox_r, oy_r, ozo_r;
  logic               olast_r;

  // divider hookup
  logic               div_start;
  logic signed [23:0] div_in;
  logic               div_done;
  logic signed [17:0] div_q;
  logic [7:0]         div_r;

  // combinational helpers
  logic signed [12:0] len_s;
  logic signed [28:0] px, py;
  logic [6:0]         nm1;
  logic signed [18:0] ang2, twoma;
  logic signed [25:0] n0_full;
  logic signed [23:0] four_a;
  logic signed [17:0] rr18;
  logic [15:0]        rr, base, a16;
  logic [1:0]         quad;
  logic [27:0]        pb_full, xr_chk;
  logic [12:0]        est13;
  logic [30:0]        xr_full;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        rsum;
  logic [29:0]        est30;
  logic [7:0]         kk;
  logic [37:0]        h_chk;
  logic [29:0]        hq;
  logic [30:0]        sb, cb;
  logic signed [31:0] ss, cs;
  logic signed [27:0] rm_a;
  logic signed [31:0] rm_b;
  logic signed [59:0] rm_p;
  logic signed [60:0] sx, sy;
  logic [8:0]         rsum9;

  // setup arithmetic
  always_comb begin
    len_s   = $signed({1'b0, len_r});
    px      = fx_r * len_s;
    py      = fy_r * len_s;
    nm1     = n_r - 7'd1;
    ang2    = {ang_r[16], ang_r, 1'b0};
    twoma   = 19'sd2 - ang2;
    n0_full = twoma * $signed({1'b0, nm1[5:0]});
    four_a  = {{5{ang_r[16]}}, ang_r, 2'b00};
  end

  // angle reduction and fold to the first octant
  always_comb begin
    rr18 = q_r[17] ? q_r + 18'sd46080 : q_r;
    rr   = rr18[15:0];
    if (rr < 16'(erv_pkg::QUARTER)) begin
      quad = 2'd0;
      base = 16'd0;
    end else if (rr < 16'(2 * erv_pkg::QUARTER)) begin
      quad = 2'd1;
      base = 16'(erv_pkg::QUARTER);
    end else if (rr < 16'(3 * erv_pkg::QUARTER)) begin
      quad = 2'd2;
      base = 16'(2 * erv_pkg::QUARTER);
    end else begin
      quad = 2'd3;
      base = 16'(3 * erv_pkg::QUARTER);
    end
    a16 = rr - base;
  end

  // radian conversion pieces
  always_comb begin
    pb_full = af_r * 15'(erv_pkg::XR_MUL_LO) + 28'(erv_pkg::XR_BIAS);
    est13   = prod_r[44:32];
    xr_chk  = {1'b0, pb_r} - est13 * 15'(erv_pkg::XR_DIV);
    xr_full = af_r * 18'(erv_pkg::XR_MUL_HI) + {18'b0, est_r};
  end

  // shared unsigned multiplier operand select
  always_comb begin
    case (cmd.op)
      erv_pkg::OP_XR_EST: begin
        mul_a = {5'b0, pb_r};
        mul_b = 32'(erv_pkg::XR_RECIP);
      end
      erv_pkg::OP_X2_MUL: begin
        mul_a = {2'b0, xr_r};
        mul_b = {2'b0, xr_r};
      end
      erv_pkg::OP_H_MUL: begin
        mul_a = {2'b0, x2_r};
        mul_b = {1'b0, t_r};
      end
      erv_pkg::OP_H_EST: begin
        mul_a = {2'b0, p_r};
        mul_b = erv_pkg::m_of(cmd.kidx);
      end
      default: begin
        mul_a = {2'b0, xr_r};
        mul_b = {1'b0, t_r};
      end
    endcase
  end

  // rounding, series step and quadrant mapping
  always_comb begin
    rsum  = prod_r + (64'd1 << 29);
    est30 = prod_r[61:32];
    kk    = erv_pkg::k_of(cmd.kidx);
    h_chk = {8'b0, p_r} - est30 * kk;
    hq    = est30 + 30'(h_chk >= {30'b0, kk});
    sb    = swap_r ? c0_r : s0_r;
    cb    = swap_r ? s0_r : c0_r;
    ss    = $signed({1'b0, sb});
    cs    = $signed({1'b0, cb});
  end

  // shared signed multiplier for the rotation
  always_comb begin
    case (cmd.op)
      erv_pkg::OP_RM1: begin
        rm_a = vx_r;
        rm_b = c_r;
      end
      erv_pkg::OP_RM2: begin
        rm_a = vy_r;
        rm_b = s_r;
      end
      erv_pkg::OP_RM3: begin
        rm_a = vx_r;
        rm_b = s_r;
      end
      default: begin
        rm_a = vy_r;
        rm_b = c_r;
      end
    endcase
    rm_p  = rm_a * rm_b;
    sx    = 61'(m1_r) - 61'(m2_r) + (61'sd1 <<< 39);
    sy    = 61'(m3_r) + 61'(m4_r) + (61'sd1 <<< 39);
    rsum9 = {1'b0, r_r} + {1'b0, rs_r};
  end

  // z rounding from the loaded item
  logic signed [28:0] vz_full, vz_rnd;
  always_comb begin
    vz_full = $signed(item.fwd_z) * $signed({1'b0, item.length});
    vz_rnd  = (vz_full + 29'sd512) >>> 10;
  end

  assign div_start = (cmd.op == erv_pkg::OP_DIV_A) || (cmd.op == erv_pkg::OP_DIV_N);
  assign div_in    = (cmd.op == erv_pkg::OP_DIV_A) ? four_a : n0_r;

  erv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (d_r),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      erv_pkg::OP_LOAD: begin
        fx_r  <= item.fwd_x;
        fy_r  <= item.fwd_y;
        len_r <= item.length;
        ang_r <= item.spread_angle;
        n_r   <= (item.vector_count > 7'(erv_pkg::MAX_VECTORS)) ?
                 7'(erv_pkg::MAX_VECTORS) : item.vector_count;
        oz_r  <= erv_pkg::clamp_out(vz_rnd[20:0]);
        idx_r <= '0;
      end
      erv_pkg::OP_SCALE: begin
        vx_r <= px[27:0];
        vy_r <= py[27:0];
        n0_r <= n0_full[23:0];
        d_r  <= {nm1[5:0], 2'b00};
      end
      erv_pkg::OP_DIV_A_SAVE: begin
        qs_r <= div_q;
        rs_r <= div_r;
      end
      erv_pkg::OP_DIV_N_SAVE: begin
        q_r   <= div_q;
        r_r   <= div_r;
        idx_r <= '0;
      end
      erv_pkg::OP_ZERO: begin
        q_r   <= '0;
        r_r   <= '0;
        qs_r  <= '0;
        rs_r  <= '0;
        idx_r <= '0;
      end
      erv_pkg::OP_FOLD: begin
        quad_r <= quad;
        if (a16 > 16'(erv_pkg::EIGHTH)) begin
          af_r   <= 13'(16'(erv_pkg::QUARTER) - a16);
          swap_r <= 1'b1;
        end else begin
          af_r   <= a16[12:0];
          swap_r <= 1'b0;
        end
      end
      erv_pkg::OP_XR_PB:  pb_r  <= pb_full[26:0];
      erv_pkg::OP_XR_FIX: est_r <= est13 + 13'(xr_chk >= 28'(erv_pkg::XR_DIV));
      erv_pkg::OP_XR_SUM: xr_r  <= xr_full[29:0];
      erv_pkg::OP_RND_X2: x2_r  <= rsum[59:30];
      erv_pkg::OP_T_INIT: t_r   <= erv_pkg::Q30_ONE;
      erv_pkg::OP_RND_P:  p_r   <= rsum[59:30];
      erv_pkg::OP_H_UPD:  t_r   <= erv_pkg::Q30_ONE - {1'b0, hq};
      erv_pkg::OP_RND_S:  s0_r  <= rsum[60:30];
      erv_pkg::OP_C_SAVE: c0_r  <= t_r;
      erv_pkg::OP_QUAD: begin
        case (quad_r)
          2'd0: begin
            s_r <= ss;
            c_r <= cs;
          end
          2'd1: begin
            s_r <= cs;
            c_r <= -ss;
          end
          2'd2: begin
            s_r <= -ss;
            c_r <= -cs;
          end
          default: begin
            s_r <= -cs;
            c_r <= ss;
          end
        endcase
      end
      erv_pkg::OP_RM1: m1_r <= rm_p;
      erv_pkg::OP_RM2: m2_r <= rm_p;
      erv_pkg::OP_RM3: m3_r <= rm_p;
      erv_pkg::OP_RM4: m4_r <= rm_p;
      erv_pkg::OP_NEXT: begin
        idx_r <= idx_r + 6'd1;
        if (rsum9 >= {1'b0, d_r}) begin
          r_r <= 8'(rsum9 - {1'b0, d_r});
          q_r <= q_r + qs_r + 18'sd1;
        end else begin
          r_r <= rsum9[7:0];
          q_r <= q_r + qs_r;
        end
      end
      default: ;
    endcase
    // shared multiplier product register
    case (cmd.op)
      erv_pkg::OP_XR_EST, erv_pkg::OP_X2_MUL, erv_pkg::OP_H_MUL,
      erv_pkg::OP_H_EST, erv_pkg::OP_S_MUL: prod_r <= mul_a * mul_b;
      default: ;
    endcase
  end

  // output register, freed when its transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.op == erv_pkg::OP_OUT) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == erv_pkg::OP_OUT) begin
      ox_r    <= erv_pkg::clamp_out(sx[60:40]);
      oy_r    <= erv_pkg::clamp_out(sy[60:40]);
      ozo_r   <= oz_r;
      olast_r <= stat.last_vec;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.out_x = ox_r;
  assign out_ch.out_y = oy_r;
  assign out_ch.out_z = ozo_r;
  assign out_ch.last  = olast_r;

  // status to the controller
  always_comb begin
    stat.div_done = div_done;
    stat.n_zero   = (n_r == 7'd0);
    stat.n_one    = (n_r == 7'd1);
    stat.last_vec = ({1'b0, idx_r} == nm1);
    stat.out_busy = ov_r;
  end

endmodule

// ===== sv/erv_ctrl.sv =====
// Sequencer: walks one item through setup, then each vector through
// fold, radian conversion, series evaluation, rotation and output
module erv_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  erv_pkg::stat_t stat,
  output erv_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCALE,
    S_DIV_A_GO,
    S_DIV_A_WAIT,
    S_DIV_N_GO,
    S_DIV_N_WAIT,
    S_ZERO,
    S_FOLD,
    S_XR_PB,
    S_XR_EST,
    S_XR_FIX,
    S_XR_SUM,
    S_X2_MUL,
    S_RND_X2,
    S_T_INIT,
    S_H_MUL,
    S_RND_P,
    S_H_EST,
    S_H_UPD,
    S_S_MUL,
    S_RND_S,
    S_C_SAVE,
    S_QUAD,
    S_RM1,
    S_RM2,
    S_RM3,
    S_RM4,
    S_OUT,
    S_NEXT
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] kidx_r, kidx_nxt;
  erv_pkg::op_t op;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    kidx_nxt  = kidx_r;
    op        = erv_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = erv_pkg::OP_LOAD;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        op = erv_pkg::OP_SCALE;
        if (stat.n_zero) begin
          state_nxt = S_IDLE;
        end else if (stat.n_one) begin
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_DIV_A_GO;
        end
      end
      S_DIV_A_GO: begin
        op        = erv_pkg::OP_DIV_A;
        state_nxt = S_DIV_A_WAIT;
      end
      S_DIV_A_WAIT: begin
        if (stat.div_done) begin
          op        = erv_pkg::OP_DIV_A_SAVE;
          state_nxt = S_DIV_N_GO;
        end
      end
      S_DIV_N_GO: begin
        op        = erv_pkg::OP_DIV_N;
        state_nxt = S_DIV_N_WAIT;
      end
      S_DIV_N_WAIT: begin
        if (stat.div_done) begin
          op        = erv_pkg::OP_DIV_N_SAVE;
          state_nxt = S_FOLD;
        end
      end
      S_ZERO: begin
        op        = erv_pkg::OP_ZERO;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        op        = erv_pkg::OP_FOLD;
        state_nxt = S_XR_PB;
      end
      S_XR_PB: begin
        op        = erv_pkg::OP_XR_PB;
        state_nxt = S_XR_EST;
      end
      S_XR_EST: begin
        op        = erv_pkg::OP_XR_EST;
        state_nxt = S_XR_FIX;
      end
      S_XR_FIX: begin
        op        = erv_pkg::OP_XR_FIX;
        state_nxt = S_XR_SUM;
      end
      S_XR_SUM: begin
        op        = erv_pkg::OP_XR_SUM;
        state_nxt = S_X2_MUL;
      end
      S_X2_MUL: begin
        op        = erv_pkg::OP_X2_MUL;
        state_nxt = S_RND_X2;
      end
      S_RND_X2: begin
        op        = erv_pkg::OP_RND_X2;
        kidx_nxt  = erv_pkg::SIN_FIRST;
        state_nxt = S_T_INIT;
      end
      S_T_INIT: begin
        op        = erv_pkg::OP_T_INIT;
        state_nxt = S_H_MUL;
      end
      S_H_MUL: begin
        op        = erv_pkg::OP_H_MUL;
        state_nxt = S_RND_P;
      end
      S_RND_P: begin
        op        = erv_pkg::OP_RND_P;
        state_nxt = S_H_EST;
      end
      S_H_EST: begin
        op        = erv_pkg::OP_H_EST;
        state_nxt = S_H_UPD;
      end
      S_H_UPD: begin
        op = erv_pkg::OP_H_UPD;
        if (kidx_r == erv_pkg::SIN_LAST) begin
          state_nxt = S_S_MUL;
        end else if (kidx_r == erv_pkg::COS_LAST) begin
          state_nxt = S_C_SAVE;
        end else begin
          kidx_nxt  = kidx_r + 4'd1;
          state_nxt = S_H_MUL;
        end
      end
      S_S_MUL: begin
        op        = erv_pkg::OP_S_MUL;
        state_nxt = S_RND_S;
      end
      S_RND_S: begin
        op        = erv_pkg::OP_RND_S;
        kidx_nxt  = erv_pkg::COS_FIRST;
        state_nxt = S_T_INIT;
      end
      S_C_SAVE: begin
        op        = erv_pkg::OP_C_SAVE;
        state_nxt = S_QUAD;
      end
      S_QUAD: begin
        op        = erv_pkg::OP_QUAD;
        state_nxt = S_RM1;
      end
      S_RM1: begin
        op        = erv_pkg::OP_RM1;
        state_nxt = S_RM2;
      end
      S_RM2: begin
        op        = erv_pkg::OP_RM2;
        state_nxt = S_RM3;
      end
      S_RM3: begin
        op        = erv_pkg::OP_RM3;
        state_nxt = S_RM4;
      end
      S_RM4: begin
        op        = erv_pkg::OP_RM4;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for a free output register
        if (!stat.out_busy) begin
          op        = erv_pkg::OP_OUT;
          state_nxt = stat.last_vec ? S_IDLE : S_NEXT;
        end
      end
      S_NEXT: begin
        op        = erv_pkg::OP_NEXT;
        state_nxt = S_FOLD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and series index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign cmd.op   = op;
  assign cmd.kidx = kidx_r;

endmodule

// ===== sv/evenly_rotated_vector_fan.sv =====
// Evenly rotated vector fan. One input transaction carries a Q2.14 forward
// vector, a count, a spread angle (1/128 degree) and a length; the block
// emits min(count, 64) Q12.4 vectors rotated about z over angles spaced
// evenly across the spread, the final one flagged by last. A count of zero
// emits nothing. Items are handled one at a time: in_ch.ready is high only
// while the block is idle, though it rises again while the last result
// still waits in the output register. Setup runs two 24-bit bit-serial
// divisions for the angle step when the count is two or more, and each
// vector passes through fold, radian conversion, the eleven steps of the
// sine and cosine series (each a multiply, round, estimate and update)
// and rotation, using the shared multipliers, before it is output.
module evenly_rotated_vector_fan (
  input  logic       clk,
  input  logic       rst_n,
  erv_in_if.sink     in_ch,
  erv_out_if.source  out_ch
);

  erv_pkg::in_item_t item;
  erv_pkg::cmd_t     cmd;
  erv_pkg::stat_t    stat;
  logic              in_ready;

  // pack the input payload
  always_comb begin
    item.fwd_x        = in_ch.fwd_x;
    item.fwd_y        = in_ch.fwd_y;
    item.fwd_z        = in_ch.fwd_z;
    item.vector_count = in_ch.vector_count;
    item.spread_angle = in_ch.spread_angle;
    item.length       = in_ch.length;
  end

  assign in_ch.ready = in_ready;

  erv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  erv_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .item   (item),
    .stat   (stat),
    .out_ch (out_ch)
  );

endmodule

// ===== sv/erv_chk.sv =====
module erv_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] out_x,
  input logic signed [16:0] out_y,
  input logic signed [16:0] out_z,
  input logic               out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_x, out_y, out_z, out_last}))
    else $error("result changed while stalled");

  // results stay within the saturation range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x >= -17'sd65520 && out_x <= 17'sd65520 &&
                  out_y >= -17'sd65520 && out_y <= 17'sd65520 &&
                  out_z >= -17'sd65520 && out_z <= 17'sd65520)
    else $error("result outside saturation range");

  // one item at a time: busy right after a transaction
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind evenly_rotated_vector_fan erv_chk u_erv_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .out_z     (out_ch.out_z),
  .out_last  (out_ch.last)
);

// ===== dv/evenly_rotated_vector_fan_tb.sv =====
`timescale 1ns / 100ps

module evenly_rotated_vector_fan_tb;

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
    logic               last;
  } fan_vec_t;

  logic clk;
  logic rst_n;

  erv_in_if  in_ch ();
  erv_out_if out_ch ();

  evenly_rotated_vector_fan dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fan_vec_t fan_expect_q[$];
  int       errors = 0;
  int       items_sent = 0;
  int       vectors_seen = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       hold_left = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint round_off(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat_out(input longint v);
    if (v > erv_pkg::OUT_LIMIT) return erv_pkg::OUT_LIMIT;
    if (v < -erv_pkg::OUT_LIMIT) return -erv_pkg::OUT_LIMIT;
    return v;
  endfunction

  // Series sine/cosine for an angle folded to at most 45 degrees, Q2.30
  task automatic octant_sincos(input longint unsigned a, output longint unsigned s,
                               output longint unsigned c);
    longint unsigned ks[5] = '{110, 72, 42, 20, 6};
    longint unsigned kc[6] = '{132, 90, 56, 30, 12, 2};
    longint unsigned one = 64'd1 << 30;
    longint unsigned half = 64'd1 << 29;
    longint unsigned xr, x2, t;
    xr = (a * 64'd3373259426 + 64'd11520) / 64'd23040;
    x2 = (xr * xr + half) >> 30;
    t = one;
    for (int i = 0; i < 5; i++) t = one - (((x2 * t + half) >> 30) / ks[i]);
    s = (xr * t + half) >> 30;
    t = one;
    for (int i = 0; i < 6; i++) t = one - (((x2 * t + half) >> 30) / kc[i]);
    c = t;
  endtask

  task automatic angle_sincos(input longint theta, output longint s, output longint c);
    longint r, q, a;
    longint unsigned s0, c0;
    r = theta % erv_pkg::TURN;
    if (r < 0) r += erv_pkg::TURN;
    q = r / erv_pkg::QUARTER;
    a = r % erv_pkg::QUARTER;
    if (a <= erv_pkg::EIGHTH) octant_sincos(a, s0, c0);
    else octant_sincos(erv_pkg::QUARTER - a, c0, s0);
    case (q)
      0: begin s = s0;  c = c0;  end
      1: begin s = c0;  c = -longint'(s0); end
      2: begin s = -longint'(s0); c = -longint'(c0); end
      default: begin s = -longint'(c0); c = s0; end
    endcase
  endtask

  // Expected fan for one accepted transaction
  task automatic predict_fan(input erv_pkg::in_item_t it);
    longint n, vx, vy, vz, oz, theta, s, c, d, num, den;
    fan_vec_t v;
    n = it.vector_count;
    if (n > erv_pkg::MAX_VECTORS) n = erv_pkg::MAX_VECTORS;
    vx = longint'(it.fwd_x) * longint'(it.length);
    vy = longint'(it.fwd_y) * longint'(it.length);
    vz = longint'(it.fwd_z) * longint'(it.length);
    oz = sat_out(round_off(vz, 10));
    for (longint i = 0; i < n; i++) begin
      theta = 0;
      if (n > 1) begin
        d = 2 * (n - 1);
        num = 2 * (longint'(it.spread_angle) * (2 * i - (n - 1))) + d;
        den = 2 * d;
        // floor division
        theta = (num >= 0) ? num / den : -((-(num + 1)) / den) - 1;
      end
      angle_sincos(theta, s, c);
      v.x = 17'(sat_out(round_off(vx * c - vy * s, 40)));
      v.y = 17'(sat_out(round_off(vx * s + vy * c, 40)));
      v.z = 17'(oz);
      v.last = (i == n - 1);
      fan_expect_q.push_back(v);
    end
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    fan_vec_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      vectors_seen++;
      if (fan_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected vector x=%0d y=%0d z=%0d last=%0d", $time,
                 out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.last);
      end else begin
        e = fan_expect_q.pop_front();
        if (out_ch.out_x !== e.x) begin
          errors++;
          $display("%0t: out_x expected %0d actual %0d", $time, e.x, out_ch.out_x);
        end
        if (out_ch.out_y !== e.y) begin
          errors++;
          $display("%0t: out_y expected %0d actual %0d", $time, e.y, out_ch.out_y);
        end
        if (out_ch.out_z !== e.z) begin
          errors++;
          $display("%0t: out_z expected %0d actual %0d", $time, e.z, out_ch.out_z);
        end
        if (out_ch.last !== e.last) begin
          errors++;
          $display("%0t: last expected %0d actual %0d", $time, e.last, out_ch.last);
        end
      end
    end
  end

  // Receiver: random idling, plus long hold-offs on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------- sender ----------------
  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_fan(input erv_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.fwd_x        = it.fwd_x;
    in_ch.fwd_y        = it.fwd_y;
    in_ch.fwd_z        = it.fwd_z;
    in_ch.vector_count = it.vector_count;
    in_ch.spread_angle = it.spread_angle;
    in_ch.length       = it.length;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_fan(it);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic erv_pkg::in_item_t mk_item(input int fx, input int fy, input int fz,
                                                input int n, input int sp, input int len);
    erv_pkg::in_item_t it;
    it.fwd_x = 16'(fx);
    it.fwd_y = 16'(fy);
    it.fwd_z = 16'(fz);
    it.vector_count = 7'(n);
    it.spread_angle = 17'(sp);
    it.length = 12'(len);
    return it;
  endfunction

  function automatic erv_pkg::in_item_t rand_item();
    erv_pkg::in_item_t it;
    int pick;
    if ($urandom_range(99) < 20) begin
      it.fwd_x = 16'($urandom);
      it.fwd_y = 16'($urandom);
      it.fwd_z = 16'($urandom);
    end else begin
      it.fwd_x = 16'($signed($urandom_range(32768)) - 16384);
      it.fwd_y = 16'($signed($urandom_range(32768)) - 16384);
      it.fwd_z = 16'($signed($urandom_range(32768)) - 16384);
    end
    // mostly small fans, a few large or saturated ones
    pick = $urandom_range(99);
    if (pick < 70) it.vector_count = 7'($urandom_range(4));
    else if (pick < 96) it.vector_count = 7'($urandom_range(16, 5));
    else it.vector_count = 7'($urandom_range(127, 17));
    if ($urandom_range(99) < 20) it.spread_angle = 17'($urandom);
    else it.spread_angle = 17'($signed($urandom_range(92160)) - 46080);
    it.length = 12'($urandom);
    return it;
  endfunction

  task automatic drain();
    int guard = 0;
    in_ch.valid = 1'b0;
    while (fan_expect_q.size() != 0 && guard < 2_000_000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    tx_idle_pct = 29;
    rx_idle_pct = 65;
    send_fan(mk_item(16384, 0, 0, 0, 11520, 4095));        // zero count
    send_fan(mk_item(16384, 0, 16384, 1, 46080, 4095));    // single vector
    send_fan(mk_item(-16384, 16384, -16384, 2, 11520, 4095)); // 45 degree fold
    send_fan(mk_item(0, -16384, 0, 3, 46080, 4095));
    send_fan(mk_item(32767, -32768, 32767, 5, -46080, 4095)); // saturation
    send_fan(mk_item(-32768, 32767, -32768, 4, 65535, 4095));
    send_fan(mk_item(11585, 11585, 0, 7, -65536, 1000));   // wraps by turns
    send_fan(mk_item(16384, 16384, 16384, 2, 0, 0));       // zero length
    send_fan(mk_item(16384, 0, -16384, 64, 46080, 2048));
    send_fan(mk_item(-1, 1, -1, 127, -23040, 4095));       // count saturates
    send_fan(mk_item(1, -1, 1, 2, 23040, 1));
    send_fan(mk_item(0, 16384, 8192, 9, 5760, 3000));
    drain();
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_fan(rand_item());
    drain();
  endtask

  // Receiver holds off while the sender keeps offering transactions
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left = 600;
    repeat (6) send_fan(mk_item(9000, -7000, 3000, 8, 30000, 4000));
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.fwd_x = '0;
    in_ch.fwd_y = '0;
    in_ch.fwd_z = '0;
    in_ch.vector_count = '0;
    in_ch.spread_angle = '0;
    in_ch.length = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random(170, 29, 65);
    test_random(170, 65, 29);
    test_backpressure();
    test_random(160, 0, 0);

    $display("covered %0d input transactions and %0d output vectors", items_sent,
             vectors_seen);
    $display("directed extremes, random fans under three idling mixes, long back-pressure");
    if (errors == 0 && fan_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d vectors missing", errors, fan_expect_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
